// ===== hdl/config_line_tokenizer_core_macros.svh =====
// ---------------------------------------------------------------------------
// config line tokenizer assertion macros
// shared property shorthands, sampled on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef CONFIG_LINE_TOKENIZER_CORE_MACROS_SVH
`define CONFIG_LINE_TOKENIZER_CORE_MACROS_SVH

// same-cycle implication
`define CLT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/clt_pkg.sv =====
// ---------------------------------------------------------------------------
// clt_pkg
// shared constants, types and helpers of the config line tokenizer
// ---------------------------------------------------------------------------
`default_nettype none

package clt_pkg;

  localparam int LINE_BYTES = 64;
  localparam int LINE_AW    = $clog2(LINE_BYTES);
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);

  localparam logic [CNT_W-1:0] LINE_CNT = CNT_W'(LINE_BYTES);

  localparam int TDATA_W = 16;
  localparam int TUSER_W = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [1:0] {
    ROLE_KEYWORD = 2'd0,
    ROLE_TYPE    = 2'd1,
    ROLE_STRING  = 2'd2,
    ROLE_NONE    = 2'd3
  } role_t;

  // controller to datapath
  typedef struct packed {
    logic intake;       // store one line byte
    logic line_start;   // clear per-line parse results
    logic scan_start;   // rewind the scan pointer
    logic scan_run;     // advance the scan
    logic phase_parse;  // 0: end search, 1: token parse
    logic parse_fin;    // close the parse at the line end
    logic emit_start;   // point at the first keyword char
    logic out_load;     // load the output register
    logic out_status;   // load a status-only result
    logic line_clear;   // drop the stored line
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
    logic emit_last;
    logic has_chars;
  } sts_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_tail(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/clt_ctrl.sv =====
// ---------------------------------------------------------------------------
// clt_ctrl
// sequencer: byte intake, end search, token parse and character emission
// ---------------------------------------------------------------------------
`default_nettype none

module clt_ctrl import clt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  input  wire logic in_tlast,
  output logic      in_tready,
  output cmd_t      cmd,
  input  sts_t      sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENDSCAN,
    S_PARSE,
    S_PICK,
    S_EMIT_RD,
    S_EMIT_LD,
    S_STATUS
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tlast) begin
            cmd.line_start = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_ENDSCAN;
          end else begin
            cmd.intake = 1'b1;
          end
        end
      end
      S_ENDSCAN: begin
        if (sts.scan_done) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_PARSE;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_PARSE: begin
        cmd.phase_parse = 1'b1;
        if (sts.scan_done) begin
          cmd.parse_fin = 1'b1;
          state_nxt     = S_PICK;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_PICK: begin
        if (sts.has_chars) begin
          cmd.emit_start = 1'b1;
          state_nxt      = S_EMIT_RD;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.emit_last) begin
            cmd.line_clear = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = 1'b1;
          cmd.line_clear = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/clt_dp.sv =====
// ---------------------------------------------------------------------------
// clt_dp
// line store, scan pointer, token boundary finder and output register
// ---------------------------------------------------------------------------
`default_nettype none

module clt_dp import clt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  wire logic [7:0]         in_byte,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,
  output logic [TUSER_W-1:0]      out_tuser,
  output logic                    out_tlast
);

  typedef enum logic [3:0] {
    P_LEAD, P_KW, P_SEP1, P_Q1, P_T1, P_SEP2, P_Q2, P_T2, P_DONE
  } pst_t;

  logic [7:0]       mem [LINE_BYTES];
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             ovf_r, ovf_nxt;
  logic             zero_r, zero_nxt;
  logic             mem_we;

  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             rdv_r, rdv_nxt;
  logic             halt_r, halt_nxt;
  logic [CNT_W-1:0] rdi_r;
  logic [7:0]       rdd_r;
  logic [CNT_W-1:0] end_r, end_nxt;

  pst_t             pst_r, pst_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             err_r, err_nxt;
  logic             typ_r, typ_nxt;
  logic [CNT_W-1:0] s0_r, s1_r, s2_r, e0_r, e1_r, e2_r;
  logic [CNT_W-1:0] s0_nxt, s1_nxt, s2_nxt, e0_nxt, e1_nxt, e2_nxt;

  logic [1:0]       seg_r, seg_nxt;
  logic             out_v_r, out_v_nxt;
  logic [TDATA_W-1:0] odata_r;
  logic [TUSER_W-1:0] ouser_r;
  logic             olast_r;

  logic [CNT_W-1:0] lim;
  logic             fetch_ok;
  logic             proc;
  logic [7:0]       c;
  logic [CNT_W-1:0] i1;
  logic [CNT_W-1:0] cur_e;
  logic [CNT_W-1:0] next_s;
  logic [CNT_W-1:0] ptr_inc;
  logic             at_seg_end;
  logic             emit_last;
  role_t            em_role;

  // scan control
  assign lim      = cmd.phase_parse ? end_r : fill_r;
  assign fetch_ok = (ptr_r < lim) && !halt_r;
  assign proc     = cmd.scan_run && rdv_r && !halt_r;
  assign c        = rdd_r;
  assign i1       = rdi_r + CNT_W'(1);
  assign ptr_inc  = ptr_r + CNT_W'(1);

  // emission segment selection
  always_comb begin
    unique case (seg_r)
      2'd0:    begin cur_e = e0_r; next_s = s1_r; em_role = ROLE_KEYWORD; end
      2'd1:    begin
        cur_e   = e1_r;
        next_s  = s2_r;
        em_role = typ_r ? ROLE_TYPE : ROLE_STRING;
      end
      default: begin cur_e = e2_r; next_s = s2_r; em_role = ROLE_STRING; end
    endcase
  end

  assign at_seg_end = (ptr_inc == cur_e);
  assign emit_last  = at_seg_end && ((seg_r + 2'd1) == cnt_r);

  assign sts.scan_done = (halt_r || (ptr_r >= lim)) && !rdv_r;
  assign sts.out_free  = !out_v_r || out_tready;
  assign sts.emit_last = emit_last;
  assign sts.has_chars = (cnt_r != 2'd0) && !err_r;

  // byte intake and line bookkeeping
  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    zero_nxt = zero_r;
    mem_we   = 1'b0;
    if (cmd.line_clear) begin
      fill_nxt = '0;
      ovf_nxt  = 1'b0;
      zero_nxt = 1'b0;
    end else if (cmd.intake && !zero_r) begin
      if (in_byte == CH_NUL) begin
        zero_nxt = 1'b1;
      end else if (fill_r < LINE_CNT) begin
        mem_we   = 1'b1;
        fill_nxt = fill_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // scan pointer, end search
  always_comb begin
    ptr_nxt  = ptr_r;
    rdv_nxt  = 1'b0;
    halt_nxt = halt_r;
    end_nxt  = end_r;
    seg_nxt  = seg_r;
    if (cmd.scan_start) begin
      ptr_nxt  = '0;
      halt_nxt = 1'b0;
    end else if (cmd.scan_run) begin
      rdv_nxt = fetch_ok;
      if (fetch_ok) ptr_nxt = ptr_inc;
    end else if (cmd.emit_start) begin
      ptr_nxt = s0_r;
      seg_nxt = 2'd0;
    end else if (cmd.out_load && !cmd.out_status) begin
      if (at_seg_end) begin
        ptr_nxt = next_s;
        seg_nxt = seg_r + 2'd1;
      end else begin
        ptr_nxt = ptr_inc;
      end
    end
    if (cmd.line_start) begin
      end_nxt = '0;
    end else if (proc && !cmd.phase_parse) begin
      // line content stops at the first hash, trailing blanks and line ends trimmed
      if (c == CH_HASH) halt_nxt = 1'b1;
      else if (!is_tail(c)) end_nxt = i1;
    end
  end

  // token boundary finder
  always_comb begin
    pst_nxt = pst_r;
    cnt_nxt = cnt_r;
    err_nxt = err_r;
    typ_nxt = typ_r;
    s0_nxt = s0_r; s1_nxt = s1_r; s2_nxt = s2_r;
    e0_nxt = e0_r; e1_nxt = e1_r; e2_nxt = e2_r;
    if (cmd.line_start) begin
      pst_nxt = P_LEAD;
      cnt_nxt = 2'd0;
      err_nxt = 1'b0;
      typ_nxt = 1'b0;
    end else if (proc && cmd.phase_parse) begin
      unique case (pst_r)
        P_LEAD: if (!is_blank(c)) begin s0_nxt = rdi_r; pst_nxt = P_KW; end
        P_KW: begin
          if (is_blank(c)) begin
            e0_nxt  = rdi_r;
            cnt_nxt = 2'd1;
            pst_nxt = P_SEP1;
          end
        end
        P_SEP1: begin
          if (c == CH_QUOTE) begin
            s1_nxt  = i1;
            pst_nxt = P_Q1;
          end else if (!is_blank(c)) begin
            s1_nxt  = rdi_r;
            pst_nxt = P_T1;
          end
        end
        P_Q1: begin
          if (c == CH_QUOTE) begin
            e1_nxt = rdi_r;
            // empty quoted second token ends the parse
            if (s1_r == rdi_r) begin
              pst_nxt = P_DONE;
            end else begin
              cnt_nxt = 2'd2;
              pst_nxt = P_SEP2;
            end
          end
        end
        P_T1: begin
          if (is_blank(c)) begin
            e1_nxt  = rdi_r;
            cnt_nxt = 2'd2;
            pst_nxt = P_SEP2;
          end
        end
        P_SEP2: begin
          if (!is_blank(c)) begin
            typ_nxt = 1'b1;
            if (c == CH_QUOTE) begin
              s2_nxt  = i1;
              pst_nxt = P_Q2;
            end else begin
              s2_nxt  = rdi_r;
              pst_nxt = P_T2;
            end
          end
        end
        P_Q2: begin
          if (c == CH_QUOTE) begin
            e2_nxt = rdi_r;
            if (s2_r != rdi_r) cnt_nxt = 2'd3;
            pst_nxt = P_DONE;
          end
        end
        P_T2: begin
          if (is_blank(c)) begin
            e2_nxt  = rdi_r;
            cnt_nxt = 2'd3;
            pst_nxt = P_DONE;
          end
        end
        P_DONE: ;
        default: pst_nxt = P_DONE;
      endcase
    end else if (cmd.parse_fin) begin
      // line end closes whatever unquoted token is open; an open quote sets the quote error
      unique case (pst_r)
        P_KW:   begin e0_nxt = end_r; cnt_nxt = 2'd1; end
        P_Q1:   err_nxt = 1'b1;
        P_T1:   begin e1_nxt = end_r; cnt_nxt = 2'd2; end
        P_Q2:   err_nxt = 1'b1;
        P_T2:   begin e2_nxt = end_r; cnt_nxt = 2'd3; end
        default: ;
      endcase
      pst_nxt = P_DONE;
    end
  end

  assign out_v_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      zero_r  <= 1'b0;
      ptr_r   <= '0;
      rdv_r   <= 1'b0;
      halt_r  <= 1'b0;
      end_r   <= '0;
      pst_r   <= P_DONE;
      cnt_r   <= 2'd0;
      err_r   <= 1'b0;
      typ_r   <= 1'b0;
      seg_r   <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
      zero_r  <= zero_nxt;
      ptr_r   <= ptr_nxt;
      rdv_r   <= rdv_nxt;
      halt_r  <= halt_nxt;
      end_r   <= end_nxt;
      pst_r   <= pst_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      typ_r   <= typ_nxt;
      seg_r   <= seg_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // line store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[fill_r[LINE_AW-1:0]] <= in_byte;
    rdd_r <= mem[ptr_r[LINE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_run) rdi_r <= ptr_r;
    s0_r <= s0_nxt; s1_r <= s1_nxt; s2_r <= s2_nxt;
    e0_r <= e0_nxt; e1_r <= e1_nxt; e2_r <= e2_nxt;
    if (cmd.out_load) begin
      if (cmd.out_status) begin
        ouser_r <= ROLE_NONE;
        olast_r <= 1'b1;
        odata_r <= {4'd0, ovf_r, err_r, (err_r ? 2'd0 : cnt_r), 8'd0};
      end else begin
        ouser_r <= em_role;
        olast_r <= emit_last;
        odata_r <= {4'd0, (emit_last & ovf_r), 1'b0,
                    (emit_last ? cnt_r : 2'd0), rdd_r};
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

// ===== hdl/config_line_tokenizer_core.sv =====
// sequence: line bytes are taken while idle; after the end-of-line item the
//   stored line is searched for its end, parsed, and its tokens emitted
// throughput: one line byte per cycle while idle; a token character is read from
//   the line store's single registered read port, then loaded once the output is free
// reset: rst_n synchronous, active low; clears the sequencer, fill count,
//   flags and output valid, the line store itself is not cleared
// ---------------------------------------------------------------------------
// config_line_tokenizer_core
// splits one stored text line into keyword, type and string tokens
// ---------------------------------------------------------------------------
`default_nettype none

module config_line_tokenizer_core import clt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // line bytes in
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] text_byte
  input  wire logic               in_tlast,   // line_end
  // tokens out
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // [7:0] token_char, [9:8] token_count,
                                              // [10] quote_error, [11] overflowed,
                                              // [15:12] zero
  output logic [TUSER_W-1:0]      out_tuser,  // [1:0] token_role
  output logic                    out_tlast   // last_of_line
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: intake while idle, then end search, token parse and emission or a status item
  clt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // line store, token boundaries and the output register; the output
  // register lets new line bytes in while the final item still waits
  clt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/clt_checker.sv =====
// ---------------------------------------------------------------------------
// clt_checker
// port-level checks of the config line tokenizer, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "config_line_tokenizer_core_macros.svh"

module clt_checker import clt_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               in_tlast,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic [TUSER_W-1:0] out_tuser,
  input wire logic               out_tlast
);

  // quote error carries no count and no character, and closes the line
  `CLT_ASSERT_IMP(a_qerr_status, out_tvalid && out_tdata[10], (out_tdata[9:8] == 2'd0) && (out_tuser == ROLE_NONE) && out_tlast, "quote error item malformed")

  // items before the final one carry no status bits and a real role
  `CLT_ASSERT_IMP(a_mid_clean, out_tvalid && !out_tlast, (out_tdata[11:8] == 4'd0) && (out_tuser != ROLE_NONE), "status bits on a non-final item")

  // the block only goes busy after an end-of-line item
  `CLT_ASSERT_IMP(a_busy_cause, $fell(in_tready), $past(in_tvalid && in_tlast), "input stalled without a line end")

  `CLT_ASSERT_NXT(a_eol_busy, in_tvalid && in_tready && in_tlast, !in_tready, "line end did not start processing")

  `CLT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled output item changed")

endmodule

bind config_line_tokenizer_core clt_checker u_clt_checker (.*);

`default_nettype wire
